// ===== rtl/smmn_pkg.sv =====
// shared constants, payload types and job type for the sensor median/mean normalizer
// no dependencies; every other file imports this package
package smmn_pkg;

  localparam int GROUPS      = 8;
  localparam int SAMPLE_BITS = 12;

  localparam int SAMPLE_W    = 12;
  localparam int LEVEL_W     = 7;
  localparam int LEVEL_SCALE = 100;
  localparam int TRIPLE      = 3;
  localparam int TPOS_W      = 2;

  localparam int SUM_W  = SAMPLE_BITS + $clog2(GROUPS);
  localparam int GCNT_W = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  // divider width covers 100 * span
  localparam int DIV_W  = SAMPLE_BITS + LEVEL_W;
  localparam int STEP_W = $clog2(DIV_W);

  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  typedef logic [SAMPLE_BITS-1:0] samp_t;
  typedef logic [SUM_W-1:0]       sum_t;

  typedef struct packed {
    logic                func;
    logic [SAMPLE_W-1:0] sample;
  } in_word_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               span_error;
  } out_word_t;

  typedef struct packed {
    sum_t  sum;
    samp_t min_seen;
    samp_t max_seen;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } job_push_t;

endpackage

// ===== rtl/smmn_front.sv =====
// front end: takes samples, tracks calibrated min/max, builds triples and median sums
// depends on smmn_pkg; pushes one job per completed set of groups
module smmn_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                smp_valid,
  output logic                smp_stall,
  input  smmn_pkg::in_word_t  smp_word,
  input  logic                q_full,
  output smmn_pkg::job_push_t push
);
  import smmn_pkg::*;

  samp_t             held0;
  samp_t             held1;
  logic [TPOS_W-1:0] tpos;
  logic [GCNT_W-1:0] gcnt;
  sum_t              sum;
  samp_t             max_seen;
  samp_t             min_seen;

  samp_t samp;
  samp_t med;
  sum_t  sum_next;
  logic  accept;
  logic  last_of_triple;
  logic  last_group;

  function automatic samp_t median3(input samp_t a, input samp_t b, input samp_t c);
    samp_t lo;
    samp_t hi;
    samp_t m;
    lo = (a < b) ? a : b;
    hi = (a > b) ? a : b;
    m  = (hi < c) ? hi : c;
    return (lo > m) ? lo : m;
  endfunction

  assign smp_stall      = q_full;
  assign accept         = smp_valid && !smp_stall;
  assign samp           = samp_t'(smp_word.sample);
  assign med            = median3(held0, held1, samp);
  assign sum_next       = sum + sum_t'(med);
  assign last_of_triple = (tpos == TPOS_W'(TRIPLE - 1));
  assign last_group     = (gcnt == GCNT_W'(GROUPS - 1));

  always_comb begin
    push.valid        = accept && smp_word.func && last_of_triple && last_group;
    push.job.sum      = sum_next;
    push.job.min_seen = min_seen;
    push.job.max_seen = max_seen;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tpos     <= '0;
      gcnt     <= '0;
      sum      <= '0;
      max_seen <= '0;
      min_seen <= '1;
    end else if (accept) begin
      if (!smp_word.func) begin
        if (max_seen < samp) max_seen <= samp;
        if (min_seen > samp) min_seen <= samp;
      end else if (!last_of_triple) begin
        tpos <= tpos + TPOS_W'(1);
      end else begin
        tpos <= '0;
        if (last_group) begin
          gcnt <= '0;
          sum  <= '0;
        end else begin
          gcnt <= gcnt + GCNT_W'(1);
          sum  <= sum_next;
        end
      end
    end
  end

  // triple slots carry payload only
  always_ff @(posedge clk) begin
    if (accept && smp_word.func) begin
      if (tpos == '0) held0 <= samp;
      if (tpos == TPOS_W'(1)) held1 <= samp;
    end
  end

endmodule

// ===== rtl/smmn_queue.sv =====
// short job queue between front and back end
// depends on smmn_pkg
module smmn_queue (
  input  logic                clk,
  input  logic                rst,
  input  smmn_pkg::job_push_t push,
  output logic                full,
  output logic                pop_valid,
  output smmn_pkg::job_t      pop_job,
  input  logic                pop
);
  import smmn_pkg::*;

  job_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign full      = (count == QCNT_W'(QDEPTH));
  assign pop_valid = (count != '0);
  assign pop_job   = slots[rd_ptr];
  assign do_push   = push.valid && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) count <= count + QCNT_W'(1);
      else if (do_pop && !do_push) count <= count - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push.job;
  end

endmodule

// ===== rtl/smmn_back.sv =====
// back end: averages the median sum, clamps and scales to percent of span
// depends on smmn_pkg; restoring divider for the normalization, one bit per cycle
module smmn_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  smmn_pkg::job_t      q_job,
  output logic                q_pop,
  output logic                res_valid,
  input  logic                res_stall,
  output smmn_pkg::out_word_t res_word
);
  import smmn_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCALE = 4'b0010,
    ST_NORM  = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t            state;
  samp_t             mn;
  samp_t             mx;
  logic [DIV_W-1:0]  num;
  logic [DIV_W-1:0]  den;
  logic [DIV_W-1:0]  rem;
  logic [STEP_W-1:0] step;
  logic              err;

  logic [DIV_W:0]   trial;
  logic [DIV_W:0]   trial_sub;
  logic             ge;
  logic [DIV_W-1:0] rem_next;
  logic [DIV_W-1:0] num_next;
  logic             last_step;
  samp_t            avg;
  samp_t            clamped;
  samp_t            diff;
  logic             res_load;

  // restoring divide step: quotient bits shift into num from the bottom
  assign trial     = {rem, num[DIV_W-1]};
  assign trial_sub = trial - {1'b0, den};
  assign ge        = (trial >= {1'b0, den});
  assign rem_next  = ge ? trial_sub[DIV_W-1:0] : trial[DIV_W-1:0];
  assign num_next  = {num[DIV_W-2:0], ge};
  assign last_step = (step == STEP_W'(DIV_W - 1));

  assign avg     = num[SAMPLE_BITS-1:0];
  assign clamped = (avg > mx) ? mx : ((avg < mn) ? mn : avg);
  assign diff    = clamped - mn;

  assign q_pop    = (state == ST_IDLE) && q_valid;
  assign res_load = (state == ST_DONE) && (!res_valid || !res_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
    end else begin
      if (res_load) res_valid <= 1'b1;
      else if (!res_stall) res_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            state <= (q_job.max_seen <= q_job.min_seen) ? ST_DONE : ST_SCALE;
          end
        end
        ST_SCALE: begin
          state <= ST_NORM;
        end
        ST_NORM: begin
          if (last_step) state <= ST_DONE;
        end
        ST_DONE: begin
          if (res_load) state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        mn   <= q_job.min_seen;
        mx   <= q_job.max_seen;
        err  <= (q_job.max_seen <= q_job.min_seen);
        // GROUPS is a power of two, so the average is a shift
        num  <= (q_job.max_seen <= q_job.min_seen) ? '0 : DIV_W'(q_job.sum / GROUPS);
        rem  <= '0;
        step <= '0;
      end
      ST_NORM: begin
        num  <= num_next;
        rem  <= rem_next;
        step <= step + STEP_W'(1);
      end
      ST_SCALE: begin
        num  <= DIV_W'(diff) * DIV_W'(LEVEL_SCALE);
        den  <= DIV_W'(mx - mn);
        rem  <= '0;
        step <= '0;
      end
      ST_DONE: begin
        if (res_load) begin
          res_word.level      <= num[LEVEL_W-1:0];
          res_word.span_error <= err;
        end
      end
      default: begin
        step <= '0;
      end
    endcase
  end

endmodule

// ===== rtl/sensor_median_mean_normalizer.sv =====
// Sensor median/mean normalizer. The front end takes one sample word per cycle: calibration
// words widen the stored min/max, measurement words are grouped in threes, and the median of
// each three is summed over GROUPS groups. A completed set goes into a two-entry job queue;
// the sample side stalls only while that queue is full. The back end takes the average as
// sum/GROUPS when it loads a job, clamps it to the calibrated range and computes
// 100*(avg-min)/(max-min) on a restoring divider, one quotient bit per cycle. In the back end
// a set is loaded in ST_IDLE, scaled in ST_SCALE, divided in ST_NORM and its result
// registered in ST_DONE; an empty or inverted span skips the scaling and division and reports
// span_error with level 0. Results wait in an output register; the next job may start
// while a result waits, but it cannot leave ST_DONE until the waiting result is taken.
// depends on smmn_pkg, smmn_front, smmn_queue, smmn_back
module sensor_median_mean_normalizer (
  input  logic                clk,
  input  logic                rst,
  input  logic                smp_valid,
  output logic                smp_stall,
  input  smmn_pkg::in_word_t  smp_word,
  output logic                res_valid,
  input  logic                res_stall,
  output smmn_pkg::out_word_t res_word
);
  import smmn_pkg::*;

  job_push_t push;
  logic      q_full;
  logic      q_valid;
  job_t      q_job;
  logic      q_pop;

  smmn_front u_front (
    .clk       (clk),
    .rst       (rst),
    .smp_valid (smp_valid),
    .smp_stall (smp_stall),
    .smp_word  (smp_word),
    .q_full    (q_full),
    .push      (push)
  );

  smmn_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (q_full),
    .pop_valid (q_valid),
    .pop_job   (q_job),
    .pop       (q_pop)
  );

  smmn_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_job     (q_job),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_word  (res_word)
  );

endmodule

// ===== bench/smmn_level_checker.sv =====
// passive checker for the sensor median/mean normalizer: predicts level words from accepted
// sample words and compares them with the accepted result words
// depends on smmn_pkg
`timescale 1ns / 1ps

module smmn_level_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                smp_valid,
  input  logic                smp_stall,
  input  smmn_pkg::in_word_t  smp_word,
  input  logic                res_valid,
  input  logic                res_stall,
  input  smmn_pkg::out_word_t res_word,
  input  logic                drain,
  output int                  fail_count,
  output int                  pending_count
);
  import smmn_pkg::*;

  // filter state as the block should hold it
  samp_t       held [2]  = '{default: '0};
  int unsigned tpos      = 0;
  int unsigned gcnt      = 0;
  sum_t        med_sum   = '0;
  samp_t       max_seen  = '0;
  samp_t       min_seen  = '1;

  out_word_t   level_q [$];
  out_word_t   want;
  int          fails     = 0;
  bit          drained   = 1'b0;

  initial begin
    fail_count    = 0;
    pending_count = 0;
  end

  function automatic samp_t median_of(samp_t a, samp_t b, samp_t c);
    samp_t lo_ab, hi_ab, lo_hc;
    lo_ab = (a < b) ? a : b;
    hi_ab = (a > b) ? a : b;
    lo_hc = (hi_ab < c) ? hi_ab : c;
    return (lo_ab > lo_hc) ? lo_ab : lo_hc;
  endfunction

  task automatic advance_filter(input in_word_t w);
    samp_t       s;
    int unsigned avg;
    int unsigned lvl;
    out_word_t   r;
    s = w.sample[SAMPLE_BITS-1:0];
    if (!w.func) begin
      if (s > max_seen) max_seen = s;
      if (s < min_seen) min_seen = s;
    end else if (tpos < 2) begin
      held[tpos] = s;
      tpos++;
    end else begin
      tpos = 0;
      med_sum = med_sum + sum_t'(median_of(held[0], held[1], s));
      gcnt++;
      if (gcnt == GROUPS) begin
        avg = int'(med_sum) / GROUPS;
        med_sum = '0;
        gcnt = 0;
        if (max_seen <= min_seen) begin
          r.level      = '0;
          r.span_error = 1'b1;
        end else begin
          if (avg > max_seen) avg = max_seen;
          if (avg < min_seen) avg = min_seen;
          lvl = (LEVEL_SCALE * (avg - min_seen)) / (max_seen - min_seen);
          r.level      = lvl[LEVEL_W-1:0];
          r.span_error = 1'b0;
        end
        level_q.push_back(r);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      // compare before predicting: a result never depends on a word taken at the same edge
      if (res_valid && !res_stall) begin
        if (level_q.size() == 0) begin
          $error("unexpected result word: level %0d span_error %0d",
                 res_word.level, res_word.span_error);
          fails++;
        end else begin
          want = level_q.pop_front();
          if (res_word.level !== want.level) begin
            $error("level: expected %0d, actual %0d", want.level, res_word.level);
            fails++;
          end
          if (res_word.span_error !== want.span_error) begin
            $error("span_error: expected %0d, actual %0d", want.span_error,
                   res_word.span_error);
            fails++;
          end
        end
      end
      if (smp_valid && !smp_stall) advance_filter(smp_word);
      if (drain && !drained) begin
        drained = 1'b1;
        if (level_q.size() != 0) begin
          $error("%0d expected level words never arrived", level_q.size());
          fails += level_q.size();
        end
      end
    end
    fail_count    <= fails;
    pending_count <= level_q.size();
  end

endmodule

// ===== bench/tb_sensor_median_mean_normalizer.sv =====
// top of the normalizer bench: clock, reset, sample word stimulus, result stall and verdict
// depends on smmn_pkg, the block and smmn_level_checker
`timescale 1ns / 1ps

module tb_sensor_median_mean_normalizer;
  import smmn_pkg::*;

  localparam int IDLE_PCT   = 28;
  localparam int STALL_LIMIT = 4000;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      smp_valid = 1'b0;
  logic      smp_stall;
  in_word_t  smp_word  = '0;
  logic      res_valid;
  logic      res_stall = 1'b0;
  out_word_t res_word;
  logic      drain     = 1'b0;

  int        fail_count;
  int        pending_count;
  bit        quiet     = 1'b0;
  int        idle_cycles = 0;
  int        word_count  = 0;
  int        cal_count   = 0;
  int        res_count   = 0;

  always #1 clk = ~clk;

  sensor_median_mean_normalizer i_dut (
    .clk       (clk),
    .rst       (rst),
    .smp_valid (smp_valid),
    .smp_stall (smp_stall),
    .smp_word  (smp_word),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_word  (res_word)
  );

  smmn_level_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .smp_valid     (smp_valid),
    .smp_stall     (smp_stall),
    .smp_word      (smp_word),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .res_word      (res_word),
    .drain         (drain),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always @(posedge clk) begin
    res_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
  end

  // watchdog on cycles with no word moving on either channel
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) res_count <= res_count + 1;
    if (rst || (smp_valid && !smp_stall) || (res_valid && !res_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_word(input logic func, input logic [SAMPLE_W-1:0] sample);
    while (!quiet && ($urandom_range(99) < IDLE_PCT)) begin
      smp_valid <= 1'b0;
      @(posedge clk);
    end
    smp_valid       <= 1'b1;
    smp_word.func   <= func;
    smp_word.sample <= sample;
    do @(posedge clk); while (smp_stall);
    word_count++;
    if (!func) cal_count++;
  endtask

  // n measurement words, with calibration words mixed in at cal_pct
  task automatic send_random(input int n, input int cal_pct, input int cal_lo,
                             input int cal_hi);
    int sent;
    int roll;
    logic [SAMPLE_W-1:0] s;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(99) < cal_pct) begin
        send_word(1'b0, SAMPLE_W'($urandom_range(cal_hi, cal_lo)));
      end else begin
        roll = $urandom_range(99);
        if (roll < 8) s = '0;
        else if (roll < 16) s = '1;
        else if (roll < 60) s = SAMPLE_W'($urandom_range(cal_hi, cal_lo));
        else s = SAMPLE_W'($urandom);
        send_word(1'b1, s);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // one full set straight after reset: span still inverted
    for (int i = 0; i < GROUPS * TRIPLE; i++) begin
      case (i % 6)
        0: send_word(1'b1, '0);
        1: send_word(1'b1, '1);
        2: send_word(1'b1, 12'haaa);
        3: send_word(1'b1, 12'h555);
        4: send_word(1'b1, 12'h800);
        default: send_word(1'b1, 12'h7ff);
      endcase
    end
    // single calibration value leaves max equal to min
    send_word(1'b0, 12'd2048);
    send_random(GROUPS * TRIPLE, 20, 2048, 2048);

    // narrow span: small divisors, clamping on both sides
    send_random(300, 10, 2040, 2056);

    // mid span with no idling on either side
    quiet = 1'b1;
    send_random(400, 15, 1000, 3000);
    quiet = 1'b0;

    // full span
    send_word(1'b0, '0);
    send_word(1'b0, '1);
    send_random(400, 15, 0, 4095);
    smp_valid <= 1'b0;

    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    drain <= 1'b1;
    repeat (3) @(posedge clk);

    $display("covered %0d sample words (%0d calibration) and %0d level words,",
             word_count, cal_count, res_count);
    $display("over inverted, equal, narrow, mid and full calibrated spans");
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
